/* rtl/pyalu_pkg.sv */
// pyalu_pkg: types and constants shared by the python integer alu
// no dependencies
`default_nettype none
package pyalu_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned KindW = 5;

	typedef enum logic [KindW-1:0] {
		K_ADD = 5'd0, K_SUB = 5'd1, K_MUL = 5'd2, K_FDIV = 5'd3, K_MOD = 5'd4,
		K_NEG = 5'd5, K_ABS = 5'd6, K_POW = 5'd7, K_CMP = 5'd8, K_AND = 5'd9,
		K_OR = 5'd10, K_XOR = 5'd11, K_NOT = 5'd12, K_SHL = 5'd13, K_SHR = 5'd14,
		K_BITLEN = 5'd15, K_POPCNT = 5'd16
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_ZERODIV = 2'd1, ST_NEGEXP = 2'd2
	} status_t;

	typedef struct packed {
		logic [KindW-1:0]        kind;
		logic signed [DataW-1:0] operand_a;
		logic signed [DataW-1:0] operand_b;
	} alu_in_t;

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic [1:0]              status;
	} alu_out_t;
endpackage
`default_nettype wire

/* rtl/pyalu_mul.sv */
// pyalu_mul: bit-serial shift-and-add multiplier, low 32 bits of the product
// depends on pyalu_pkg
`default_nettype none
module pyalu_mul import pyalu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DataW-1:0] x,
	input  wire logic [DataW-1:0] y,
	output logic                  done,
	output logic [DataW-1:0]      prod
);
	logic [DataW-1:0] mc_q, mp_q, acc_q;
	logic [5:0]       cnt_q;
	logic             run_q;

	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DataW - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit a cycle, multiplicand shifts left
	always_ff @(posedge clk) begin
		if (go) begin
			mc_q  <= x;
			mp_q  <= y;
			acc_q <= '0;
		end else if (run_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[DataW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[DataW-1:1]};
		end
	end
endmodule
`default_nettype wire

/* rtl/python_integer_alu_unit.sv */
// python_integer_alu_unit: 32-bit signed alu with python floor/mod semantics
// depends on pyalu_pkg and pyalu_mul
//
// channel   | ports                | handshake
// command   | start, busy, cmd     | taken when start && !busy
// result    | done, result         | done high one cycle, no back-pressure
//
// one-step ops and error cases pass S_EXEC then S_FIN before done rises;
// floordiv, mod, bitlen and popcount take one bit per cycle in S_DIV or S_SCAN,
// and mul waits in S_MUL for the serial multiplier. pow does one multiply per
// set exponent bit and one square per bit below the top set bit, each a serial
// multiply; the shared serial multiplier sets the pace of mul and pow.
// reset clears the sequencer; busy is low after reset; the receiver cannot stall.
`default_nettype none
module python_integer_alu_unit import pyalu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire alu_in_t  cmd,
	output logic          busy,
	output logic          done,
	output alu_out_t      result
);
	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_MUL, S_DIV, S_SCAN, S_PSQ, S_PMUL, S_FIN
	} state_t;

	state_t           state_q;
	logic [4:0]       kind_q;
	logic [DataW-1:0] a_q, b_q;
	logic [DataW-1:0] rem_q, quo_q, dvs_q, mag_q, acc_q, base_q, exp_q;
	logic [5:0]       cnt_q;
	logic             mgo_q;
	logic             mdone;
	logic [DataW-1:0] mprod, mx, my;
	logic [DataW:0]   trial;
	logic [DataW-1:0] rem_sh, q_fix, r_fix;
	logic             sa, sb;

	pyalu_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mgo_q), .x(mx), .y(my),
		.done(mdone), .prod(mprod)
	);

	// pow: cnt_q[0] low = multiply acc by base, high = square base
	assign mx = (kind_q == K_POW) ? (cnt_q[0] ? base_q : acc_q) : a_q;
	assign my = (kind_q == K_POW) ? base_q : b_q;
	assign busy = (state_q != S_IDLE);

	assign sa     = a_q[DataW-1];
	assign sb     = b_q[DataW-1];
	assign rem_sh = {rem_q[DataW-2:0], mag_q[DataW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	// sign fix-up of the magnitude quotient and remainder toward floor
	always_comb begin
		logic [DataW-1:0] q0, r0;
		q0 = (sa ^ sb) ? (DataW'(0) - quo_q) : quo_q;
		r0 = sa ? (DataW'(0) - rem_q) : rem_q;
		q_fix = q0;
		r_fix = r0;
		if (rem_q != '0 && (sa != sb)) begin
			q_fix = q0 - DataW'(1);
			r_fix = r0 + b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			mgo_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done  <= 1'b0;
			mgo_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: begin
					cnt_q <= '0;
					case (kind_q)
						K_MUL: begin mgo_q <= 1'b1; state_q <= S_MUL; end
						K_FDIV, K_MOD: state_q <= (b_q == '0) ? S_FIN : S_DIV;
						K_POW: state_q <= sb ? S_FIN : S_PSQ;
						K_BITLEN, K_POPCNT: state_q <= S_SCAN;
						default: state_q <= S_FIN;
					endcase
				end
				S_MUL: if (mdone) state_q <= S_FIN;
				S_DIV, S_SCAN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DataW - 1)) state_q <= S_FIN;
				end
				S_PSQ: begin
					// per exponent bit: acc*base when the bit is set, then base*base while higher bits remain
					if (exp_q == '0) state_q <= S_FIN;
					else if (!cnt_q[0]) begin
						if (exp_q[0]) begin
							mgo_q   <= 1'b1;
							state_q <= S_PMUL;
						end else begin
							cnt_q <= cnt_q ^ 6'd1;
						end
					end else if (exp_q[DataW-1:1] == '0) state_q <= S_FIN;
					else begin mgo_q <= 1'b1; state_q <= S_PMUL; end
				end
				S_PMUL: if (mdone) begin
					cnt_q   <= cnt_q ^ 6'd1;
					state_q <= S_PSQ;
				end
				S_FIN: begin done <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				kind_q <= cmd.kind;
				a_q    <= cmd.operand_a;
				b_q    <= cmd.operand_b;
			end
			S_EXEC: begin
				mag_q  <= sa ? (DataW'(0) - a_q) : a_q;
				dvs_q  <= sb ? (DataW'(0) - b_q) : b_q;
				rem_q  <= '0;
				quo_q  <= '0;
				acc_q  <= (kind_q == K_POW) ? DataW'(1) : '0;
				base_q <= a_q;
				exp_q  <= b_q;
			end
			S_DIV: begin
				mag_q <= {mag_q[DataW-2:0], 1'b0};
				if (!trial[DataW]) begin
					rem_q <= trial[DataW-1:0];
					quo_q <= {quo_q[DataW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DataW-2:0], 1'b0};
				end
			end
			S_SCAN: begin
				mag_q <= {1'b0, mag_q[DataW-1:1]};
				if (mag_q[0]) begin
					acc_q <= acc_q + DataW'(1);
					quo_q <= DataW'(cnt_q) + DataW'(1);
				end
			end
			S_PMUL: if (mdone) begin
				if (cnt_q[0]) begin
					base_q <= mprod;
					exp_q  <= {1'b0, exp_q[DataW-1:1]};
				end else begin
					acc_q <= mprod;
				end
			end
			default: ;
		endcase
	end

	logic [DataW-1:0] res_v;
	logic [1:0]       res_s;
	always_comb begin
		res_v = '0;
		res_s = ST_OK;
		case (kind_q)
			K_ADD:    res_v = a_q + b_q;
			K_SUB:    res_v = a_q - b_q;
			K_MUL:    res_v = mprod;
			K_FDIV:   if (b_q == '0) res_s = ST_ZERODIV; else res_v = q_fix;
			K_MOD:    if (b_q == '0) res_s = ST_ZERODIV; else res_v = r_fix;
			K_NEG:    res_v = DataW'(0) - a_q;
			K_ABS:    res_v = sa ? (DataW'(0) - a_q) : a_q;
			K_POW:    if (sb) res_s = (a_q == '0) ? ST_ZERODIV : ST_NEGEXP;
			          else res_v = acc_q;
			K_CMP:    res_v = ($signed(a_q) < $signed(b_q)) ? '1 :
			                  (($signed(a_q) > $signed(b_q)) ? DataW'(1) : '0);
			K_AND:    res_v = a_q & b_q;
			K_OR:     res_v = a_q | b_q;
			K_XOR:    res_v = a_q ^ b_q;
			K_NOT:    res_v = ~a_q;
			K_SHL:    if (b_q[DataW-1:5] == '0) res_v = a_q << b_q[4:0];
			K_SHR:    if (b_q[DataW-1:5] == '0) res_v = $signed(a_q) >>> b_q[4:0];
			K_BITLEN: res_v = quo_q;
			K_POPCNT: res_v = acc_q;
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			result.value  <= res_v;
			result.status <= res_s;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("command not taken");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result held more than one cycle");
endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for python_integer_alu_unit, directed table then random words
// depends on pyalu_pkg and the alu rtl
`default_nettype none
module tb import pyalu_pkg::*; ();
	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	alu_in_t  cmd = '0;
	logic     busy;
	logic     done;
	alu_out_t result;

	alu_out_t expected_q[$];
	int       fail_cnt = 0;
	int       send_idle_pct = 0;
	bit       running = 1'b1;

	python_integer_alu_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	function automatic alu_out_t alu_predict(input alu_in_t c);
		alu_out_t r;
		logic signed [31:0] a, b;
		logic signed [63:0] q, rm;
		logic [31:0] acc, base, e, m;
		a = c.operand_a;
		b = c.operand_b;
		r.value = '0;
		r.status = ST_OK;
		case (c.kind)
			K_ADD: r.value = a + b;
			K_SUB: r.value = a - b;
			K_MUL: r.value = a * b;
			K_FDIV, K_MOD: begin
				if (b == 0) begin
					r.status = ST_ZERODIV;
				end else begin
					q = 64'(a) / 64'(b);
					rm = 64'(a) % 64'(b);
					// floor toward minus infinity, remainder follows divisor
					if (rm != 0 && (a[31] != b[31])) begin
						q = q - 1;
						rm = rm + 64'(b);
					end
					r.value = (c.kind == K_FDIV) ? q[31:0] : rm[31:0];
				end
			end
			K_NEG: r.value = 32'd0 - a;
			K_ABS: r.value = mag32(a);
			K_POW: begin
				if (b < 0) begin
					r.status = (a == 0) ? ST_ZERODIV : ST_NEGEXP;
				end else begin
					acc = 32'd1;
					base = a;
					e = b;
					while (e != 0) begin
						if (e[0]) acc = acc * base;
						base = base * base;
						e = e >> 1;
					end
					r.value = acc;
				end
			end
			K_CMP: r.value = (a < b) ? -32'sd1 : ((a > b) ? 32'sd1 : 32'sd0);
			K_AND: r.value = a & b;
			K_OR: r.value = a | b;
			K_XOR: r.value = a ^ b;
			K_NOT: r.value = ~a;
			K_SHL: if (b >= 0 && b <= 31) r.value = a << b;
			K_SHR: if (b >= 0 && b <= 31) r.value = a >>> b;
			K_BITLEN: begin
				m = mag32(a);
				for (int i = 0; i < 32; i++) if (m[i]) r.value = 32'(i + 1);
			end
			K_POPCNT: begin
				m = mag32(a);
				for (int i = 0; i < 32; i++) r.value = r.value + m[i];
			end
			default: ;
		endcase
		return r;
	endfunction

	// results are accepted at the edge that ends the strobe cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: value %0d", result.value);
				fail_cnt++;
			end else begin
				alu_out_t x;
				x = expected_q.pop_front();
				if (x.value !== result.value) begin
					$error("value: expected %0d, actual %0d", x.value, result.value);
					fail_cnt++;
				end
				if (x.status !== result.status) begin
					$error("status: expected %0d, actual %0d", x.status, result.status);
					fail_cnt++;
				end
			end
		end
	end

	// sends one word; the table may give an expected result in place of the predictor
	// start stays high after the word is taken, the caller drops it before waiting
	task automatic send_word(input alu_in_t c, input bit use_given, input alu_out_t given);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(use_given ? given : alu_predict(c));
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return 32'($urandom_range(0, 40)) - 32'd20;
			1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
			2: return 32'($urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	typedef struct {
		kind_t       k;
		logic [31:0] a, b;
		bit          given;
		logic [31:0] v;
		status_t     s;
	} dir_row_t;

	localparam logic [31:0] MinInt = 32'h8000_0000;
	localparam logic [31:0] MaxInt = 32'h7fff_ffff;

	dir_row_t dir_rows[] = '{
		'{K_ADD, MaxInt, 32'd1, 1, MinInt, ST_OK},
		'{K_SUB, MinInt, 32'd1, 1, MaxInt, ST_OK},
		'{K_MUL, MaxInt, MaxInt, 0, 0, ST_OK},
		'{K_FDIV, 32'd7, 32'd0, 1, 0, ST_ZERODIV},
		'{K_MOD, 32'd7, 32'd0, 1, 0, ST_ZERODIV},
		'{K_FDIV, MinInt, -32'sd1, 1, MinInt, ST_OK},
		'{K_MOD, MinInt, -32'sd1, 1, 0, ST_OK},
		'{K_FDIV, -32'sd7, 32'd2, 1, -32'sd4, ST_OK},
		'{K_MOD, -32'sd7, 32'd2, 1, 32'd1, ST_OK},
		'{K_MOD, 32'd7, -32'sd2, 1, -32'sd1, ST_OK},
		'{K_NEG, MinInt, 32'd0, 1, MinInt, ST_OK},
		'{K_ABS, MinInt, 32'd5, 1, MinInt, ST_OK},
		'{K_POW, 32'd3, MaxInt, 0, 0, ST_OK},
		'{K_POW, 32'd0, -32'sd1, 1, 0, ST_ZERODIV},
		'{K_POW, 32'd2, MinInt, 1, 0, ST_NEGEXP},
		'{K_POW, 32'd0, 32'd0, 1, 32'd1, ST_OK},
		'{K_CMP, MinInt, MaxInt, 1, -32'sd1, ST_OK},
		'{K_AND, 32'hf0f0_f0f0, 32'hffff_0000, 0, 0, ST_OK},
		'{K_OR, 32'hf0f0_f0f0, 32'h0f0f_0000, 0, 0, ST_OK},
		'{K_XOR, 32'hffff_ffff, 32'h5555_5555, 0, 0, ST_OK},
		'{K_NOT, 32'd0, 32'd0, 1, 32'hffff_ffff, ST_OK},
		'{K_SHL, 32'd1, 32'd32, 1, 0, ST_OK},
		'{K_SHR, MinInt, 32'd31, 1, 32'hffff_ffff, ST_OK},
		'{K_BITLEN, MinInt, 32'd0, 1, 32'd32, ST_OK},
		'{K_POPCNT, MinInt, 32'd0, 1, 32'd1, ST_OK}
	};

	initial begin
		alu_in_t c;
		alu_out_t g;
		int phase_pct[3] = '{31, 48, 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			c.kind = dir_rows[i].k;
			c.operand_a = dir_rows[i].a;
			c.operand_b = dir_rows[i].b;
			g.value = dir_rows[i].v;
			g.status = dir_rows[i].s;
			send_word(c, dir_rows[i].given, g);
		end
		// unused opcodes
		c = '{5'd17, 32'd1, 32'd1};
		send_word(c, 1, '{32'd0, ST_OK});
		c = '{5'd31, MinInt, MaxInt};
		send_word(c, 1, '{32'd0, ST_OK});
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = phase_pct[ph];
			// let outstanding results drain before the next phase
			start <= 1'b0;
			while (expected_q.size() != 0) @(posedge clk);
			for (int n = 0; n < 610; n++) begin
				c.kind = ($urandom_range(19) == 0) ? 5'($urandom_range(17, 31))
					: 5'($urandom_range(0, 16));
				c.operand_a = rand_operand();
				c.operand_b = rand_operand();
				// pow with large exponents is slow, keep most small
				if (c.kind == K_POW && $urandom_range(9) != 0)
					c.operand_b = 32'($urandom_range(0, 40)) - 32'd4;
				send_word(c, 0, g);
			end
		end
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		running = 1'b0;
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50_000_000;
		if (running) begin
			$display("Some tests failed");
			$finish;
		end
	end
endmodule

/* python_integer_alu_unit.f */
rtl/pyalu_pkg.sv
rtl/pyalu_mul.sv
rtl/python_integer_alu_unit.sv
tb/tb.sv
